// ===== rtl/core/bgd_pkg.sv =====
// Shared types, codes and reset values for the button gesture detector.
package bgd_pkg;

  localparam int TIME_WIDTH_DEF = 16;
  localparam int QDEPTH_DEF     = 4;

  localparam int STEP_W     = 10;
  localparam int THR_W      = 16;
  localparam int CLICK_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MAX_EV     = 3;

  typedef enum logic [2:0] {
    GST_SHORT      = 3'd0,
    GST_MULTI      = 3'd1,
    GST_LONG       = 3'd2,
    GST_SUPER      = 3'd3,
    GST_SHORT_LONG = 3'd4,
    GST_RELEASE    = 3'd5,
    GST_PRESS      = 3'd6
  } gesture_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_LOW = 3'd0,
    CFG_SCAN_STEP  = 3'd1,
    CFG_DEBOUNCE   = 3'd2,
    CFG_LONG       = 3'd3,
    CFG_SUPER_LONG = 3'd4,
    CFG_CLICK_GAP  = 3'd5
  } cfg_idx_t;

  localparam logic              ACTIVE_LOW_RST = 1'b1;
  localparam logic [STEP_W-1:0] SCAN_STEP_RST  = 10'd10;
  localparam logic [THR_W-1:0]  DEBOUNCE_RST   = 16'd20;
  localparam logic [THR_W-1:0]  LONG_RST       = 16'd1000;
  localparam logic [THR_W-1:0]  SUPER_LONG_RST = 16'd3000;
  localparam logic [THR_W-1:0]  CLICK_GAP_RST  = 16'd300;

  localparam logic [CLICK_W-1:0] CLICK_MAX = 4'd15;

  // events of one tick, in order; cnt is 1..3 when queued
  typedef struct packed {
    logic [1:0]           cnt;
    gesture_t [MAX_EV-1:0] ev;
  } bundle_t;

endpackage

// ===== rtl/core/bgd_front.sv =====
// Front end: configuration registers, tick timers and per-tick event classification.
module bgd_front
  import bgd_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_push,
  input  logic                  in_pin_level,
  output logic                  in_full,
  input  logic                  q_full,
  output logic                  q_push,
  output bundle_t               q_wdata
);

  localparam int CW = (TIME_WIDTH > THR_W) ? TIME_WIDTH : THR_W;
  localparam int SW = ((TIME_WIDTH > STEP_W) ? TIME_WIDTH : STEP_W) + 1;

  logic                  active_low_r;
  logic [STEP_W-1:0]     scan_step_r;
  logic [THR_W-1:0]      debounce_r, long_r, super_long_r, click_gap_r;

  logic [TIME_WIDTH-1:0] press_time_r, press_time_nxt;
  logic [TIME_WIDTH-1:0] gap_time_r, gap_time_nxt;
  logic [CLICK_W-1:0]    click_r, click_nxt, click_tmp;
  logic                  long_sent_r, long_sent_nxt;
  logic                  super_sent_r, super_sent_nxt;

  logic                  accept, pressed;
  logic [SW-1:0]         press_sum, gap_sum;
  logic [TIME_WIDTH-1:0] press_add, gap_add;
  logic [CW-1:0]         prev_c, add_c, gap_c, deb_c, long_c, super_c, gapthr_c, prev_full_c;
  logic [1:0]            n;
  gesture_t [MAX_EV-1:0] ev;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign pressed = active_low_r ? !in_pin_level : in_pin_level;

  assign press_sum = SW'(press_time_r) + SW'(scan_step_r);
  assign gap_sum   = SW'(gap_time_r) + SW'(scan_step_r);
  // saturate at the top of the timer range
  assign press_add = (|press_sum[SW-1:TIME_WIDTH]) ? '1 : press_sum[TIME_WIDTH-1:0];
  assign gap_add   = (|gap_sum[SW-1:TIME_WIDTH]) ? '1 : gap_sum[TIME_WIDTH-1:0];

  assign prev_c      = CW'(press_time_r);
  assign prev_full_c = prev_c;
  assign add_c       = CW'(press_add);
  assign gap_c       = CW'(gap_add);
  assign deb_c       = CW'(debounce_r);
  assign long_c      = CW'(long_r);
  assign super_c     = CW'(super_long_r);
  assign gapthr_c    = CW'(click_gap_r);

  always_comb begin
    press_time_nxt = press_time_r;
    gap_time_nxt   = gap_time_r;
    click_nxt      = click_r;
    long_sent_nxt  = long_sent_r;
    super_sent_nxt = super_sent_r;
    click_tmp      = click_r;
    n              = 2'd0;
    ev             = {MAX_EV{GST_SHORT}};
    if (accept) begin
      if (pressed) begin
        press_time_nxt = press_add;
        gap_time_nxt   = '0;
        if (prev_c <= deb_c && add_c > deb_c) begin
          ev[n] = GST_PRESS;
          n     = n + 2'd1;
        end
        if (add_c >= long_c && !long_sent_r) begin
          ev[n]         = (click_r == 4'd1) ? GST_SHORT_LONG : GST_LONG;
          n             = n + 2'd1;
          long_sent_nxt = 1'b1;
          click_nxt     = '0;
        end
        if (add_c >= super_c && !super_sent_r) begin
          ev[n]          = GST_SUPER;
          n              = n + 2'd1;
          super_sent_nxt = 1'b1;
          click_nxt      = '0;
        end
      end else begin
        if (press_time_r != '0) begin
          if (prev_full_c > deb_c) begin
            if (!long_sent_r && click_tmp < CLICK_MAX)
              click_tmp = click_tmp + 4'd1;
            ev[n] = GST_RELEASE;
            n     = n + 2'd1;
          end
          press_time_nxt = '0;
          long_sent_nxt  = 1'b0;
          super_sent_nxt = 1'b0;
        end
        if (click_tmp != '0) begin
          gap_time_nxt = gap_add;
          if (gap_c > gapthr_c) begin
            ev[n]        = (click_tmp == 4'd1) ? GST_SHORT : GST_MULTI;
            n            = n + 2'd1;
            click_tmp    = '0;
            gap_time_nxt = '0;
          end
        end
        click_nxt = click_tmp;
      end
    end
  end

  assign q_push      = accept && (n != 2'd0);
  assign q_wdata.cnt = n;
  assign q_wdata.ev  = ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_low_r <= ACTIVE_LOW_RST;
      scan_step_r  <= SCAN_STEP_RST;
      debounce_r   <= DEBOUNCE_RST;
      long_r       <= LONG_RST;
      super_long_r <= SUPER_LONG_RST;
      click_gap_r  <= CLICK_GAP_RST;
      press_time_r <= '0;
      gap_time_r   <= '0;
      click_r      <= '0;
      long_sent_r  <= 1'b0;
      super_sent_r <= 1'b0;
    end else begin
      press_time_r <= press_time_nxt;
      gap_time_r   <= gap_time_nxt;
      click_r      <= click_nxt;
      long_sent_r  <= long_sent_nxt;
      super_sent_r <= super_sent_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ACTIVE_LOW: active_low_r <= cfg_wdata[0];
          CFG_SCAN_STEP:  scan_step_r  <= cfg_wdata[STEP_W-1:0];
          CFG_DEBOUNCE:   debounce_r   <= cfg_wdata[THR_W-1:0];
          CFG_LONG:       long_r       <= cfg_wdata[THR_W-1:0];
          CFG_SUPER_LONG: super_long_r <= cfg_wdata[THR_W-1:0];
          CFG_CLICK_GAP:  click_gap_r  <= cfg_wdata[THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/core/bgd_queue.sv =====
// Short FIFO of per-tick event bundles between front and back end.
module bgd_queue
  import bgd_pkg::*;
#(
  parameter int DEPTH = QDEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t wdata,
  output logic    full,
  input  logic    pop,
  output bundle_t rdata,
  output logic    empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0]   LAST = PW'(DEPTH - 1);
  localparam logic [CNTW-1:0] FULLC = CNTW'(DEPTH);

  bundle_t         mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] count_r;
  logic            do_push, do_pop;

  assign full    = (count_r == FULLC);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push)
      mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push)
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
      if (do_pop)
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
      if (do_push && !do_pop)
        count_r <= count_r + CNTW'(1);
      else if (do_pop && !do_push)
        count_r <= count_r - CNTW'(1);
    end
  end

endmodule

// ===== rtl/core/bgd_back.sv =====
// Back end: unpacks queued bundles into single events, one beat per cycle while the receiver pops.
module bgd_back
  import bgd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  bundle_t    q_rdata,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [2:0] out_gesture,
  output logic       out_last_of_tick
);

  logic       out_valid_r;
  gesture_t   gesture_r;
  logic       last_r;
  logic [1:0] idx_r;
  logic       load, last_ev;

  // output register refills whenever it is free or being drained
  assign load    = !q_empty && (!out_valid_r || out_pop);
  assign last_ev = (idx_r == q_rdata.cnt - 2'd1);
  assign q_pop   = load && last_ev;

  assign out_empty        = !out_valid_r;
  assign out_gesture      = gesture_r;
  assign out_last_of_tick = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= last_ev ? 2'd0 : idx_r + 2'd1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      gesture_r <= q_rdata.ev[idx_r];
      last_r    <= last_ev;
    end
  end

endmodule

// ===== rtl/core/button_gesture_detector_top.sv =====
// Button gesture detector: scan ticks in, click / long-press / release events out.
//
// Input channel: one beat per scan tick carrying the raw pin level (in_push,
// in_full). Result channel: one beat per event (out_empty, out_pop), each with
// its gesture code and a flag on the last event of its tick; ticks that cause
// no event give no beat. Configuration: cfg_we/cfg_index/cfg_wdata write a
// register at the clock edge; the user must write it only while the block is
// idle, and the block itself does not enforce this. The first event of a tick
// reaches the outputs through the bundle FIFO and then the output register. A
// tick is accepted every cycle while the bundle FIFO has room; the output side
// drains one event per cycle while the receiver pops, so the sustained tick
// rate is set by the event unpacker.
// Reset: thresholds return to their defaults, timers, click count and sent
// flags clear, FIFO and output register empty.
// When the receiver stalls, the output register holds its event, the FIFO
// fills with pending ticks, and in_full rises once it has QUEUE_DEPTH entries.
module button_gesture_detector_top
  import bgd_pkg::*;
#(
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QDEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_push,
  input  logic                  in_pin_level,
  output logic                  in_full,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [2:0]            out_gesture,
  output logic                  out_last_of_tick
);

  logic    q_push, q_full, q_pop, q_empty;
  bundle_t q_wdata, q_rdata;

  bgd_front #(.TIME_WIDTH(TIME_WIDTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_push      (in_push),
    .in_pin_level (in_pin_level),
    .in_full      (in_full),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  bgd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  bgd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_rdata          (q_rdata),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_gesture      (out_gesture),
    .out_last_of_tick (out_last_of_tick)
  );

endmodule
